### src/mfpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mfpc_pkg
// Types, register codes and scaling functions shared by the motor fader
// position controller.
// ---------------------------------------------------------------------------
package mfpc_pkg;

    localparam int POS_W       = 12;
    localparam int LEVEL_W     = 16;
    localparam int TIME_W      = 32;
    localparam int MS_W        = 8;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 3;

    // register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TOUCH_THRESHOLD    = 3'd0,
        CFG_STOP_TOLERANCE     = 3'd1,
        CFG_SLOW_ZONE          = 3'd2,
        CFG_PULSE_LENGTH_MS    = 3'd3,
        CFG_REPORT_INTERVAL_MS = 3'd4,
        CFG_REPORT_DELTA       = 3'd5,
        CFG_MOTOR_PRESENT      = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        DRV_BRAKE    = 2'd0,
        DRV_FORWARD  = 2'd1,
        DRV_BACKWARD = 2'd2
    } drive_t;

    typedef struct packed {
        logic [POS_W-1:0]   wiper_position;
        logic [POS_W-1:0]   touch_sample;
        logic [TIME_W-1:0]  now_ms;
        logic               target_load;
        logic [LEVEL_W-1:0] target_level;
        logic               button_chosen;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         motor_drive;
        logic               report_valid;
        logic [LEVEL_W-1:0] report_level;
        logic               touched;
        logic               target_active;
    } out_item_t;

    typedef struct packed {
        logic [POS_W-1:0] touch_threshold;
        logic [POS_W-1:0] stop_tolerance;
        logic [POS_W-1:0] slow_zone;
        logic [MS_W-1:0]  pulse_length_ms;
        logic [MS_W-1:0]  report_interval_ms;
        logic [POS_W-1:0] report_delta;
        logic             motor_present;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        touch_count;
        logic              touch_state;
        logic              was_touched;
        logic              target_valid;
        logic [POS_W-1:0]  target_position;
        logic              sent_valid;
        logic [POS_W-1:0]  sent_position;
        logic [TIME_W-1:0] last_report_time;
        logic [TIME_W-1:0] pulse_start_time;
        logic              pulse_active;
        drive_t            drive_state;
    } ctl_state_t;

    localparam logic [1:0] TOUCH_COUNT_MAX = 2'd3;

    // floor(level * 4095 / 65535): level / 16 is exact or one too high
    function automatic logic [POS_W-1:0] level_to_pos(input logic [LEVEL_W-1:0] level);
        logic [POS_W-1:0] q;
        logic [27:0]      num;
        logic [27:0]      prod;
        q    = level[LEVEL_W-1:4];
        num  = {level, 12'd0} - {12'd0, level};
        prod = {q, 16'd0} - {16'd0, q};
        if (num < prod) begin
            q = q - 12'd1;
        end
        return q;
    endfunction

    // floor(pos * 65535 / 4095) = pos * 16 + floor(pos / 273)
    function automatic logic [LEVEL_W-1:0] pos_to_level(input logic [POS_W-1:0] pos);
        logic [19:0] prod;
        logic [3:0]  q;
        logic [12:0] bound;
        prod  = {pos, 8'd0} - {4'd0, pos, 4'd0};
        q     = prod[19:16];
        bound = 13'((17'(q) + 17'd1) * 17'd273);
        if ({1'b0, pos} >= bound) begin
            q = q + 4'd1;
        end
        return {pos, 4'd0} + {12'd0, q};
    endfunction

endpackage
`default_nettype wire

### src/mfpc_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mfpc_core
// Next-state and result logic for one fader sample.
// ---------------------------------------------------------------------------
module mfpc_core
    import mfpc_pkg::*;
(
    input  cfg_t       cfg,
    input  ctl_state_t state_cur,
    input  in_item_t   item,
    output ctl_state_t state_nxt,
    output out_item_t  result
);

    logic [POS_W-1:0]  tgt_pos;
    logic [POS_W-1:0]  err_mag;
    drive_t            err_dir;
    logic [POS_W-1:0]  sent_mag;
    logic [TIME_W-1:0] report_age;
    logic [TIME_W-1:0] pulse_age;
    logic              touch_hit;

    assign tgt_pos    = item.target_load ? level_to_pos(item.target_level)
                                         : state_cur.target_position;
    assign err_mag    = (tgt_pos > item.wiper_position) ? tgt_pos - item.wiper_position
                                                        : item.wiper_position - tgt_pos;
    assign err_dir    = (tgt_pos > item.wiper_position) ? DRV_BACKWARD : DRV_FORWARD;
    assign sent_mag   = (item.wiper_position > state_cur.sent_position)
                        ? item.wiper_position - state_cur.sent_position
                        : state_cur.sent_position - item.wiper_position;
    // wrapping time differences
    assign report_age = item.now_ms - state_cur.last_report_time;
    assign pulse_age  = item.now_ms - state_cur.pulse_start_time;
    assign touch_hit  = item.touch_sample > cfg.touch_threshold;

    always_comb begin
        state_nxt = state_cur;
        result    = '0;

        if (item.target_load) begin
            state_nxt.target_position = tgt_pos;
            state_nxt.target_valid    = 1'b1;
        end

        // saturating touch qualifier
        if (touch_hit) begin
            if (state_cur.touch_count == TOUCH_COUNT_MAX) begin
                state_nxt.touch_state = 1'b1;
            end else begin
                state_nxt.touch_count = state_cur.touch_count + 2'd1;
            end
        end else begin
            if (state_cur.touch_count == 2'd0) begin
                state_nxt.touch_state = 1'b0;
            end else begin
                state_nxt.touch_count = state_cur.touch_count - 2'd1;
            end
        end

        if (state_nxt.touch_state) begin
            if (state_nxt.target_valid) begin
                state_nxt.target_valid = 1'b0;
                state_nxt.drive_state  = DRV_BRAKE;
            end
            if (report_age > TIME_W'(cfg.report_interval_ms) && item.button_chosen &&
                (!state_cur.sent_valid || sent_mag > cfg.report_delta)) begin
                state_nxt.sent_position    = item.wiper_position;
                state_nxt.sent_valid       = 1'b1;
                state_nxt.last_report_time = item.now_ms;
                result.report_valid        = 1'b1;
                result.report_level        = pos_to_level(item.wiper_position);
            end
            state_nxt.was_touched = 1'b1;
        end else begin
            if (state_cur.was_touched) begin
                state_nxt.was_touched = 1'b0;
                state_nxt.sent_valid  = 1'b0;
            end
            if (cfg.motor_present && state_nxt.target_valid) begin
                if (err_mag < cfg.stop_tolerance) begin
                    state_nxt.drive_state  = DRV_BRAKE;
                    state_nxt.target_valid = 1'b0;
                end else if (err_mag < cfg.slow_zone) begin
                    if (!state_cur.pulse_active) begin
                        state_nxt.pulse_start_time = item.now_ms;
                        state_nxt.pulse_active     = 1'b1;
                        state_nxt.drive_state      = err_dir;
                    end else if (pulse_age > TIME_W'(cfg.pulse_length_ms)) begin
                        state_nxt.drive_state  = DRV_BRAKE;
                        state_nxt.pulse_active = 1'b0;
                    end
                end else begin
                    state_nxt.drive_state = err_dir;
                end
            end
        end

        result.motor_drive   = state_nxt.drive_state;
        result.touched       = state_nxt.touch_state;
        result.target_active = state_nxt.target_valid;
    end

endmodule
`default_nettype wire

### src/motor_fader_position_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// an accepted beat waits in the input register until the output register is free
// throughput: one beat per cycle, limited only by the result channel's ready
// reset: aresetn low at a clock edge empties both registers, clears the control
//   state and restores every configuration register to its documented default
// ---------------------------------------------------------------------------
// motor_fader_position_controller
// Touch-qualified motorized fader controller: drives the motor toward a target
// level and reports changed positions while the fader is touched.
// ---------------------------------------------------------------------------
module motor_fader_position_controller
    import mfpc_pkg::*;
(
    input  wire                          aclk,
    input  wire                          aresetn,
    // sample channel
    input  wire                          s_valid,
    output logic                         s_ready,
    input  in_item_t                     s_data,
    // result channel
    output logic                         m_valid,
    input  wire                          m_ready,
    output out_item_t                    m_data,
    // configuration write port
    input  wire                          cfg_wr_en,
    input  wire  [CFG_INDEX_W-1:0]       cfg_index,
    input  wire  [CFG_DATA_W-1:0]        cfg_wdata
);

    // configuration registers
    cfg_t       cfg_reg;

    // input register stage
    logic       in_valid_reg;
    in_item_t   in_data_reg;

    // output register stage
    logic       out_valid_reg;
    out_item_t  out_data_reg;

    // controller state, updated once per beat that moves to the output stage
    ctl_state_t state_reg;
    ctl_state_t state_next;
    out_item_t  result_next;

    logic       advance;

    // the output register frees up in the same cycle it is taken, so while m_ready
    // stays high beats flow every cycle without a bubble
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // configuration decode; index seven is ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.touch_threshold    <= 12'd600;
            cfg_reg.stop_tolerance     <= 12'd400;
            cfg_reg.slow_zone          <= 12'd800;
            cfg_reg.pulse_length_ms    <= 8'd15;
            cfg_reg.report_interval_ms <= 8'd10;
            cfg_reg.report_delta       <= 12'd15;
            cfg_reg.motor_present      <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TOUCH_THRESHOLD:    cfg_reg.touch_threshold    <= cfg_wdata;
                CFG_STOP_TOLERANCE:     cfg_reg.stop_tolerance     <= cfg_wdata;
                CFG_SLOW_ZONE:          cfg_reg.slow_zone          <= cfg_wdata;
                CFG_PULSE_LENGTH_MS:    cfg_reg.pulse_length_ms    <= cfg_wdata[MS_W-1:0];
                CFG_REPORT_INTERVAL_MS: cfg_reg.report_interval_ms <= cfg_wdata[MS_W-1:0];
                CFG_REPORT_DELTA:       cfg_reg.report_delta       <= cfg_wdata;
                CFG_MOTOR_PRESENT:      cfg_reg.motor_present      <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // per-sample control logic
    mfpc_core u_core (
        .cfg       (cfg_reg),
        .state_cur (state_reg),
        .item      (in_data_reg),
        .state_nxt (state_next),
        .result    (result_next)
    );

    // state commits only when the beat leaves the input stage; all zero is brake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result_next;
        end
    end

    // a report is only produced while the fader is held
    a_report_needs_touch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.report_valid |-> m_data.touched)
        else $error("report without qualified touch");

    // no stale level leaks out on a sample without a report
    a_level_zero_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.report_valid |-> m_data.report_level == 16'd0)
        else $error("report level set without report");

    // touching the fader always cancels a pending target
    a_touch_cancels_target: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.touched |-> !m_data.target_active)
        else $error("target pending while touched");

    // touch is only qualified after the counter has saturated
    a_touch_after_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg.touch_state) |-> state_reg.touch_count == TOUCH_COUNT_MAX)
        else $error("touch qualified before counter saturated");

endmodule
`default_nettype wire

### test/fader_step_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fader_step_checker
// Watches the sample, result and configuration ports of the fader controller.
// It keeps its own copy of the control state and registers, predicts one
// result beat per accepted sample beat, and compares each result field by field.
// ---------------------------------------------------------------------------
module fader_step_checker
    import mfpc_pkg::*;
(
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    input  wire                    s_ready,
    input  in_item_t               s_data,
    input  wire                    m_valid,
    input  wire                    m_ready,
    input  out_item_t              m_data,
    input  wire                    cfg_wr_en,
    input  wire  [CFG_INDEX_W-1:0] cfg_index,
    input  wire  [CFG_DATA_W-1:0]  cfg_wdata,
    output int                     fail_count,
    output int                     pend_count
);

    localparam logic [11:0] DEF_TOUCH_THRESHOLD = 12'd600;
    localparam logic [11:0] DEF_STOP_TOLERANCE  = 12'd400;
    localparam logic [11:0] DEF_SLOW_ZONE       = 12'd800;
    localparam logic [7:0]  DEF_PULSE_LENGTH    = 8'd15;
    localparam logic [7:0]  DEF_REPORT_INTERVAL = 8'd10;
    localparam logic [11:0] DEF_REPORT_DELTA    = 12'd15;

    // register mirror
    logic [11:0] thr_level;
    logic [11:0] stop_tol;
    logic [11:0] slow_width;
    logic [7:0]  pulse_len;
    logic [7:0]  report_gap;
    logic [11:0] report_step;
    logic        motor_on;

    // control state mirror
    logic [1:0]  touch_cnt;
    logic        touching;
    logic        prev_touched;
    logic        tgt_pending;
    logic [11:0] tgt_pos;
    logic        reported;
    logic [11:0] reported_pos;
    logic [31:0] report_stamp;
    logic [31:0] pulse_stamp;
    logic        pulsing;
    drive_t      drive;

    out_item_t   expected_steps[$];
    out_item_t   want;

    function automatic logic [11:0] pos_distance(input logic [11:0] a, input logic [11:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // advances the state mirror by one sample and returns the result it causes
    function automatic out_item_t fader_step(input in_item_t smp);
        out_item_t   res;
        logic [11:0] err;
        logic [31:0] elapsed;
        drive_t      toward;
        res = '0;
        if (smp.target_load) begin
            tgt_pos     = 12'((32'(smp.target_level) * 32'd4095) / 32'd65535);
            tgt_pending = 1'b1;
        end
        if (smp.touch_sample > thr_level) begin
            if (touch_cnt == TOUCH_COUNT_MAX) begin
                touching = 1'b1;
            end else begin
                touch_cnt = touch_cnt + 2'd1;
            end
        end else begin
            if (touch_cnt == 2'd0) begin
                touching = 1'b0;
            end else begin
                touch_cnt = touch_cnt - 2'd1;
            end
        end
        if (touching) begin
            if (tgt_pending) begin
                tgt_pending = 1'b0;
                drive       = DRV_BRAKE;
            end
            elapsed = smp.now_ms - report_stamp;
            if (elapsed > 32'(report_gap) && smp.button_chosen) begin
                if (!reported || pos_distance(smp.wiper_position, reported_pos) > report_step) begin
                    reported_pos     = smp.wiper_position;
                    reported         = 1'b1;
                    report_stamp     = smp.now_ms;
                    res.report_valid = 1'b1;
                    res.report_level = 16'((32'(smp.wiper_position) * 32'd65535) / 32'd4095);
                end
            end
            prev_touched = 1'b1;
        end else begin
            if (prev_touched) begin
                prev_touched = 1'b0;
                reported     = 1'b0;
            end
            if (motor_on && tgt_pending) begin
                err    = pos_distance(tgt_pos, smp.wiper_position);
                toward = (tgt_pos > smp.wiper_position) ? DRV_BACKWARD : DRV_FORWARD;
                if (err < stop_tol) begin
                    drive       = DRV_BRAKE;
                    tgt_pending = 1'b0;
                end else if (err < slow_width) begin
                    elapsed = smp.now_ms - pulse_stamp;
                    if (!pulsing) begin
                        pulse_stamp = smp.now_ms;
                        pulsing     = 1'b1;
                        drive       = toward;
                    end else if (elapsed > 32'(pulse_len)) begin
                        drive   = DRV_BRAKE;
                        pulsing = 1'b0;
                    end
                end else begin
                    drive = toward;
                end
            end
        end
        res.motor_drive   = drive;
        res.touched       = touching;
        res.target_active = tgt_pending;
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, got_val);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            thr_level    = DEF_TOUCH_THRESHOLD;
            stop_tol     = DEF_STOP_TOLERANCE;
            slow_width   = DEF_SLOW_ZONE;
            pulse_len    = DEF_PULSE_LENGTH;
            report_gap   = DEF_REPORT_INTERVAL;
            report_step  = DEF_REPORT_DELTA;
            motor_on     = 1'b1;
            touch_cnt    = '0;
            touching     = 1'b0;
            prev_touched = 1'b0;
            tgt_pending  = 1'b0;
            tgt_pos      = '0;
            reported     = 1'b0;
            reported_pos = '0;
            report_stamp = '0;
            pulse_stamp  = '0;
            pulsing      = 1'b0;
            drive        = DRV_BRAKE;
            expected_steps.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_steps.size() == 0) begin
                    $error("result beat with no sample waiting");
                    fail_count++;
                end else begin
                    want = expected_steps.pop_front();
                    check_field("motor_drive", want.motor_drive, m_data.motor_drive);
                    check_field("report_valid", want.report_valid, m_data.report_valid);
                    check_field("report_level", want.report_level, m_data.report_level);
                    check_field("touched", want.touched, m_data.touched);
                    check_field("target_active", want.target_active, m_data.target_active);
                end
            end
            if (s_valid && s_ready) begin
                expected_steps.push_back(fader_step(s_data));
            end
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_index))
                    CFG_TOUCH_THRESHOLD:    thr_level   = cfg_wdata;
                    CFG_STOP_TOLERANCE:     stop_tol    = cfg_wdata;
                    CFG_SLOW_ZONE:          slow_width  = cfg_wdata;
                    CFG_PULSE_LENGTH_MS:    pulse_len   = cfg_wdata[7:0];
                    CFG_REPORT_INTERVAL_MS: report_gap  = cfg_wdata[7:0];
                    CFG_REPORT_DELTA:       report_step = cfg_wdata;
                    CFG_MOTOR_PRESENT:      motor_on    = cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        pend_count = expected_steps.size();
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Regression for the motor fader position controller: a directed opening,
// then touch, drive and noise sessions with random content under several
// register settings, with random stalls on both channels. The checker beside
// the block predicts and compares every result beat.
// ---------------------------------------------------------------------------
module testbench;
    import mfpc_pkg::*;

    localparam int LIMIT_CYCLES    = 500000;
    localparam int HOLD_OFF_CYCLES = 200;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_item_t              m_data;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int          fail_count;
    int          pend_count;
    int          cycle_count;
    int          samples_sent;
    bit          send_gaps_on;
    bit          recv_stalls_on;
    bit          hold_off_req;
    int          cur_thr;
    int          wiper;
    logic [31:0] clock_ms;

    motor_fader_position_controller uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    fader_step_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pend_count (pend_count)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // watchdog: ends a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin : result_sink
        int burst;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                // long hold-off so the block fills and backs up the sample side
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end else if (recv_stalls_on && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 16);
                m_ready <= 1'b0;
                repeat (burst - 1) @(negedge aclk);
            end else begin
                // ready stretch of random length
                m_ready <= 1'b1;
                burst = $urandom_range(0, 15);
                repeat (burst) @(negedge aclk);
            end
        end
    end

    function automatic in_item_t make_sample(input logic [11:0] pos, input logic [11:0] touch,
                                             input logic [31:0] now, input logic load,
                                             input logic [15:0] level, input logic chosen);
        in_item_t smp;
        smp.wiper_position = pos;
        smp.touch_sample   = touch;
        smp.now_ms         = now;
        smp.target_load    = load;
        smp.target_level   = level;
        smp.button_chosen  = chosen;
        return smp;
    endfunction

    function automatic int clamp_pos(input int v);
        return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
    endfunction

    // touch sample that counts as touching, now and then a dropout
    function automatic logic [11:0] touch_high();
        if (cur_thr >= 4095 || $urandom_range(0, 7) == 0) begin
            return 12'($urandom_range(0, 4095));
        end
        return 12'($urandom_range(cur_thr + 1, 4095));
    endfunction

    // touch sample at or below the threshold, now and then a spike
    function automatic logic [11:0] touch_low();
        if ($urandom_range(0, 15) == 0) begin
            return 12'($urandom_range(0, 4095));
        end
        return 12'($urandom_range(0, cur_thr));
    endfunction

    // millisecond time mostly creeps forward, sometimes jumps or sits near wrap
    task automatic advance_clock(input int max_inc);
        if ($urandom_range(0, 49) == 0) begin
            clock_ms = $urandom_range(0, 1) ? 32'($urandom) : 32'hFFFF_FFF0;
        end else begin
            clock_ms = clock_ms + 32'($urandom_range(0, max_inc));
        end
    endtask

    // one sample beat; valid stays up between back-to-back beats
    task automatic send_sample(input in_item_t smp);
        int gap;
        if (send_gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= smp;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
    endtask

    // sender pause until every result has come back
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pend_count == 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_settings(input int thr, input int tol, input int slow, input int plen,
                                  input int rint, input int rdel, input int motor);
        write_reg(CFG_TOUCH_THRESHOLD, 12'(thr));
        write_reg(CFG_STOP_TOLERANCE, 12'(tol));
        write_reg(CFG_SLOW_ZONE, 12'(slow));
        write_reg(CFG_PULSE_LENGTH_MS, 12'(plen));
        write_reg(CFG_REPORT_INTERVAL_MS, 12'(rint));
        write_reg(CFG_REPORT_DELTA, 12'(rdel));
        write_reg(CFG_MOTOR_PRESENT, 12'(motor));
        cur_thr = thr;
    endtask

    // mix of touch sessions, drive-to-target sessions and raw noise
    task automatic run_mixed(input int count);
        int          goal;
        int          kind;
        int          len;
        int          stride;
        int          d;
        logic [15:0] lvl;
        logic [11:0] aim;
        goal = samples_sent + count;
        while (samples_sent < goal) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                // finger on the fader: wiper wanders, reports get throttled
                len = $urandom_range(3, 30);
                repeat (len) begin
                    advance_clock(25);
                    wiper = clamp_pos(wiper + $urandom_range(0, 200) - 100);
                    send_sample(make_sample(12'(wiper), touch_high(), clock_ms,
                                            $urandom_range(0, 9) == 0, 16'($urandom),
                                            $urandom_range(0, 7) != 0));
                end
            end else if (kind < 8) begin
                // new target, then the wiper closes in on it through the slow zone
                lvl = 16'($urandom);
                aim = lvl[15:4];
                advance_clock(12);
                send_sample(make_sample(12'(wiper), touch_low(), clock_ms, 1'b1, lvl, 1'b1));
                len = $urandom_range(5, 40);
                repeat (len) begin
                    advance_clock(12);
                    d      = int'(aim) - wiper;
                    stride = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400)
                                                         : $urandom_range(0, 40);
                    if ($urandom_range(0, 7) == 0) begin
                        stride = -stride;
                    end
                    wiper = clamp_pos(wiper + ((d > 0) ? stride : -stride));
                    send_sample(make_sample(12'(wiper), touch_low(), clock_ms,
                                            $urandom_range(0, 19) == 0, 16'($urandom),
                                            1'($urandom_range(0, 1))));
                end
            end else begin
                // anything goes
                len = $urandom_range(1, 5);
                repeat (len) begin
                    send_sample(make_sample(12'($urandom), 12'($urandom), 32'($urandom),
                                            1'($urandom_range(0, 1)), 16'($urandom),
                                            1'($urandom_range(0, 1))));
                end
            end
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        samples_sent   = 0;
        send_gaps_on   = 1'b1;
        recv_stalls_on = 1'b1;
        hold_off_req   = 1'b0;
        cur_thr        = 600;
        wiper          = 2048;
        clock_ms       = '0;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // directed opening under the reset settings
        // far target at full scale: full speed backward
        send_sample(make_sample(12'd0, 12'd0, 32'd0, 1'b1, 16'hFFFF, 1'b0));
        // on target: brake and clear it
        send_sample(make_sample(12'd4095, 12'd0, 32'd5, 1'b0, 16'd0, 1'b0));
        // target at zero from the top end: full speed forward
        send_sample(make_sample(12'd4095, 12'd0, 32'd6, 1'b1, 16'd0, 1'b0));
        // slow zone: pulse starts, holds, expires, restarts
        send_sample(make_sample(12'd600, 12'd0, 32'd10, 1'b0, 16'd0, 1'b0));
        send_sample(make_sample(12'd600, 12'd0, 32'd20, 1'b0, 16'd0, 1'b0));
        send_sample(make_sample(12'd600, 12'd0, 32'd26, 1'b0, 16'd0, 1'b0));
        send_sample(make_sample(12'd600, 12'd0, 32'd27, 1'b0, 16'd0, 1'b0));
        // touch qualifies on the fourth sample above threshold, target loaded there dies
        send_sample(make_sample(12'd4095, 12'd601, 32'd40, 1'b0, 16'd0, 1'b1));
        send_sample(make_sample(12'd4095, 12'd601, 32'd41, 1'b0, 16'd0, 1'b1));
        send_sample(make_sample(12'd4095, 12'd601, 32'd42, 1'b0, 16'd0, 1'b1));
        send_sample(make_sample(12'd4095, 12'd4095, 32'd43, 1'b1, 16'h8000, 1'b1));
        // too soon, then change equal to delta, then just over it
        send_sample(make_sample(12'd4095, 12'd4095, 32'd44, 1'b0, 16'd0, 1'b1));
        send_sample(make_sample(12'd4080, 12'd4095, 32'd60, 1'b0, 16'd0, 1'b1));
        send_sample(make_sample(12'd4079, 12'd4095, 32'd61, 1'b0, 16'd0, 1'b1));
        // no button chosen: silent, then bottom of travel reported
        send_sample(make_sample(12'd0, 12'd4095, 32'd72, 1'b0, 16'd0, 1'b0));
        send_sample(make_sample(12'd0, 12'd4095, 32'd80, 1'b0, 16'd0, 1'b1));
        // release with samples exactly at threshold
        send_sample(make_sample(12'd0, 12'd600, 32'd81, 1'b0, 16'd0, 1'b1));
        send_sample(make_sample(12'd0, 12'd600, 32'd82, 1'b0, 16'd0, 1'b1));
        send_sample(make_sample(12'd0, 12'd600, 32'd83, 1'b0, 16'd0, 1'b1));
        send_sample(make_sample(12'd0, 12'd0, 32'd84, 1'b0, 16'd0, 1'b1));
        // mid-scale target one step off: brake at once
        send_sample(make_sample(12'd2048, 12'd0, 32'd100, 1'b1, 16'h8000, 1'b0));
        // time at the wrap point
        send_sample(make_sample(12'd100, 12'd0, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b0));

        run_mixed(150);

        // moderate settings; the result side holds off while beats keep coming
        drain();
        apply_settings(900, 300, 700, 10, 5, 20, 1);
        send_gaps_on = 1'b0;
        hold_off_req = 1'b1;
        run_mixed(60);
        send_gaps_on = 1'b1;
        drain();
        run_mixed(90);

        // everything at zero: zero error drives forward
        drain();
        apply_settings(0, 0, 0, 0, 0, 0, 1);
        send_sample(make_sample(12'd0, 12'd0, clock_ms, 1'b1, 16'd0, 1'b0));
        run_mixed(200);

        // everything at full scale, motor absent: never touched
        drain();
        apply_settings(4095, 4095, 4095, 255, 255, 4095, 0);
        run_mixed(100);

        // tolerance above slow zone: no pulsing at all
        drain();
        apply_settings(2000, 500, 300, 40, 30, 100, 1);
        run_mixed(150);

        // random settings
        drain();
        apply_settings($urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 4095), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 4095),
                       $urandom_range(0, 1));
        run_mixed(150);

        // motor absent with touches: cancelling still brakes
        drain();
        apply_settings(700, 200, 1200, 20, 8, 10, 0);
        run_mixed(150);

        // reset values again, both sides running flat out
        drain();
        apply_settings(600, 400, 800, 15, 10, 15, 1);
        send_gaps_on   = 1'b0;
        recv_stalls_on = 1'b0;
        run_mixed(200);

        drain();
        repeat (8) @(negedge aclk);
        if (fail_count == 0 && pend_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
